// File: design/lpfp_pkg.sv
package lpfp_pkg;

	// parser phases
	typedef enum logic [1:0] {
		PH_HEADER,
		PH_TEXT,
		PH_CONTROL,
		PH_HALTED
	} phase_t;

	// result kinds
	localparam logic [1:0] KIND_TEXT  = 2'd0;
	localparam logic [1:0] KIND_KEY   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// error codes
	localparam logic [1:0] ERR_LENGTH  = 2'd0;
	localparam logic [1:0] ERR_CONTROL = 2'd1;
	localparam logic [1:0] ERR_NUL     = 2'd2;

	// control frame layout
	localparam logic [7:0] CTRL_TYPE_KEYSYM = 8'd1;
	localparam int unsigned CTRL_FRAME_LEN  = 6;

	// queue between front and back
	localparam int unsigned Q_DEPTH = 2;

	// input item
	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  text_byte;
		logic        frame_last;
		logic [31:0] key_symbol;
		logic        key_pressed;
		logic [1:0]  error_code;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		logic       conn_reset;
		logic [7:0] data;
		logic       is_nul;
		logic       is_one;
		logic       le_one;
	} cls_item_t;

endpackage

// File: design/length_prefixed_frame_parser_top.sv
// a result item passes through the front stage register, the queue and the
// output register after its byte is accepted
// throughput: one byte per cycle unless stalled, set by the back-end parser update
// a two-entry queue between classifier and parser absorbs output stalls
// reset: asynchronous, active low; parser returns to header phase, queue and
// output register empty
module length_prefixed_frame_parser_top #(
	parameter int unsigned MAX_FRAME_BYTES = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  lpfp_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output lpfp_pkg::out_item_t result
);
	import lpfp_pkg::*;

	logic      q_push;
	cls_item_t q_push_item;
	logic      q_full;
	logic      q_pop;
	cls_item_t q_pop_item;
	logic      q_empty;

	// classifier
	lpfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push       (q_push),
		.push_item  (q_push_item),
		.q_full     (q_full)
	);

	// decoupling queue
	lpfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (q_pop_item),
		.empty     (q_empty)
	);

	// parser and output register
	lpfp_back #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_item       (q_pop_item),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef ASSERT_OFF
	// queue never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("queue written while full");

	// parser never consumes while a result is held back
	a_pop_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !(result_valid && result_stall))
		else $error("parser advanced over a stalled result");

	// an accepted item moves on or waits on a full queue
	a_front_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> (q_push || q_full))
		else $error("accepted item lost in front stage");
`endif

endmodule

// File: design/lpfp_front.sv
module lpfp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  lpfp_pkg::in_item_t  item,
	output logic                push,
	output lpfp_pkg::cls_item_t push_item,
	input  logic                q_full
);
	import lpfp_pkg::*;

	logic      fe_valid_s1;
	cls_item_t fe_item_s1;
	logic      accept;

	// hold the item while the queue is full
	assign item_stall = fe_valid_s1 && q_full;
	assign accept     = item_valid && !item_stall;
	assign push       = fe_valid_s1 && !q_full;
	assign push_item  = fe_item_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_valid_s1 <= 1'b0;
		end else if (accept) begin
			fe_valid_s1 <= 1'b1;
		end else if (push) begin
			fe_valid_s1 <= 1'b0;
		end
	end

	// classify the byte on the way in
	always_ff @(posedge clk) begin
		if (accept) begin
			fe_item_s1.conn_reset <= item.mode;
			fe_item_s1.data       <= item.data_byte;
			fe_item_s1.is_nul     <= (item.data_byte == 8'd0);
			fe_item_s1.is_one     <= (item.data_byte == CTRL_TYPE_KEYSYM);
			fe_item_s1.le_one     <= (item.data_byte[7:1] == 7'd0);
		end
	end

endmodule

// File: design/lpfp_queue.sv
module lpfp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lpfp_pkg::cls_item_t push_item,
	output logic                full,
	input  logic                pop,
	output lpfp_pkg::cls_item_t pop_item,
	output logic                empty
);
	import lpfp_pkg::*;

	localparam int unsigned PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int unsigned CW = $clog2(Q_DEPTH + 1);

	cls_item_t         entry_q [Q_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign full     = (count_q == CW'(Q_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: design/lpfp_back.sv
module lpfp_back #(
	parameter int unsigned MAX_FRAME_BYTES = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  lpfp_pkg::cls_item_t q_item,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_stall,
	output lpfp_pkg::out_item_t result
);
	import lpfp_pkg::*;

	localparam int unsigned RW = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [30:0] MAX_LEN = 31'(MAX_FRAME_BYTES);
	localparam logic [2:0]  CTRL_LAST_IDX = 3'(CTRL_FRAME_LEN - 1);

	phase_t        phase_q, phase_d;
	logic [1:0]    hdr_cnt_q, hdr_cnt_d;
	logic [23:0]   hdr_q, hdr_d;
	logic [RW-1:0] rem_q, rem_d;
	logic [2:0]    idx_q, idx_d;
	logic          pressed_q, pressed_d;
	logic [23:0]   sym_q, sym_d;

	logic          out_valid_q;
	out_item_t     out_item_q;
	logic          res_load;
	out_item_t     res_d;

	logic [31:0]   hdr_full;
	logic [30:0]   hdr_len;
	logic [31:0]   sym_full;

	assign hdr_full = {hdr_q, q_item.data};
	assign hdr_len  = hdr_full[30:0];
	assign sym_full = {sym_q, q_item.data};

	// take the next item when the output register is free
	assign pop          = !q_empty && (!out_valid_q || !result_stall);
	assign result_valid = out_valid_q;
	assign result       = out_item_q;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= '0;
			hdr_q     <= '0;
			rem_q     <= '0;
			idx_q     <= '0;
			pressed_q <= 1'b0;
			sym_q     <= '0;
		end else begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			hdr_q     <= hdr_d;
			rem_q     <= rem_d;
			idx_q     <= idx_d;
			pressed_q <= pressed_d;
			sym_q     <= sym_d;
		end
	end

	// next state and result
	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		hdr_d     = hdr_q;
		rem_d     = rem_q;
		idx_d     = idx_q;
		pressed_d = pressed_q;
		sym_d     = sym_q;
		res_load  = 1'b0;
		res_d     = '0;
		if (pop) begin
			if (q_item.conn_reset) begin
				phase_d   = PH_HEADER;
				hdr_cnt_d = '0;
				hdr_d     = '0;
				rem_d     = '0;
				idx_d     = '0;
				pressed_d = 1'b0;
				sym_d     = '0;
			end else begin
				unique case (phase_q)
					PH_HEADER: begin
						hdr_d     = hdr_full[23:0];
						hdr_cnt_d = hdr_cnt_q + 2'd1;
						if (hdr_cnt_q == 2'd3) begin
							priority if (hdr_len == '0 || hdr_len > MAX_LEN) begin
								phase_d          = PH_HALTED;
								res_load         = 1'b1;
								res_d.kind       = KIND_ERROR;
								res_d.error_code = ERR_LENGTH;
							end else if (hdr_full[31]) begin
								if (hdr_len != 31'(CTRL_FRAME_LEN)) begin
									phase_d          = PH_HALTED;
									res_load         = 1'b1;
									res_d.kind       = KIND_ERROR;
									res_d.error_code = ERR_CONTROL;
								end else begin
									idx_d     = '0;
									sym_d     = '0;
									pressed_d = 1'b0;
									phase_d   = PH_CONTROL;
								end
							end else begin
								rem_d   = hdr_len[RW-1:0];
								phase_d = PH_TEXT;
							end
						end
					end
					PH_TEXT: begin
						res_load = 1'b1;
						if (q_item.is_nul) begin
							phase_d          = PH_HALTED;
							res_d.kind       = KIND_ERROR;
							res_d.error_code = ERR_NUL;
						end else begin
							res_d.kind      = KIND_TEXT;
							res_d.text_byte = q_item.data;
							if (rem_q <= RW'(1)) begin
								res_d.frame_last = 1'b1;
								rem_d            = '0;
								phase_d          = PH_HEADER;
							end else begin
								rem_d = rem_q - 1'b1;
							end
						end
					end
					PH_CONTROL: begin
						// type byte, then state byte, then keysym bytes
						priority if (idx_q == 3'd0 && !q_item.is_one) begin
							phase_d          = PH_HALTED;
							res_load         = 1'b1;
							res_d.kind       = KIND_ERROR;
							res_d.error_code = ERR_CONTROL;
						end else if (idx_q == 3'd1 && !q_item.le_one) begin
							phase_d          = PH_HALTED;
							res_load         = 1'b1;
							res_d.kind       = KIND_ERROR;
							res_d.error_code = ERR_CONTROL;
						end else begin
							if (idx_q == 3'd1) begin
								pressed_d = q_item.data[0];
							end else if (idx_q != 3'd0) begin
								sym_d = sym_full[23:0];
							end
							if (idx_q == CTRL_LAST_IDX) begin
								res_load          = 1'b1;
								res_d.kind        = KIND_KEY;
								res_d.key_symbol  = sym_full;
								res_d.key_pressed = pressed_q;
								idx_d             = '0;
								phase_d           = PH_HEADER;
							end else begin
								idx_d = idx_q + 3'd1;
							end
						end
					end
					PH_HALTED: begin
					end
					default: begin
					end
				endcase
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_item_q <= res_d;
		end
	end

endmodule

// File: tb/length_prefixed_frame_parser_top_tb.sv
module length_prefixed_frame_parser_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lpfp_pkg::*;

	localparam int unsigned MAX_LEN = 65536;
	localparam int unsigned RANDOM_ITEMS = 1500;
	localparam int unsigned QUIET_TAIL = 250;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned PRINT_CAP = 40;
	localparam int unsigned MAX_FRAME_PART = 24;

	// one row of the directed stimulus
	typedef struct packed {
		logic      typed;
		in_item_t  it;
		out_item_t want;
	} step_row_t;

	localparam out_item_t NO_RESULT = '0;
	localparam out_item_t WANT_TEXT_FF = '{KIND_TEXT, 8'hFF, 1'b1, 32'd0, 1'b0, 2'd0};
	localparam out_item_t WANT_KEY = '{KIND_KEY, 8'h00, 1'b0, 32'hDEADBEEF, 1'b1, 2'd0};
	localparam out_item_t WANT_ERR_LEN = '{KIND_ERROR, 8'h00, 1'b0, 32'd0, 1'b0, ERR_LENGTH};
	localparam out_item_t WANT_ERR_CTL = '{KIND_ERROR, 8'h00, 1'b0, 32'd0, 1'b0, ERR_CONTROL};
	localparam out_item_t WANT_ERR_NUL = '{KIND_ERROR, 8'h00, 1'b0, 32'd0, 1'b0, ERR_NUL};

	// directed stimulus: one-byte text frame, key event, too long, bad control length, nul
	localparam step_row_t DIRECTED [30] = '{
		'{1'b0, '{1'b0, 8'h00}, NO_RESULT},
		'{1'b0, '{1'b0, 8'h00}, NO_RESULT},
		'{1'b0, '{1'b0, 8'h00}, NO_RESULT},
		'{1'b0, '{1'b0, 8'h01}, NO_RESULT},
		'{1'b1, '{1'b0, 8'hFF}, WANT_TEXT_FF},
		'{1'b0, '{1'b0, 8'h80}, NO_RESULT},
		'{1'b0, '{1'b0, 8'h00}, NO_RESULT},
		'{1'b0, '{1'b0, 8'h00}, NO_RESULT},
		'{1'b0, '{1'b0, 8'h06}, NO_RESULT},
		'{1'b0, '{1'b0, 8'h01}, NO_RESULT},
		'{1'b0, '{1'b0, 8'h01}, NO_RESULT},
		'{1'b0, '{1'b0, 8'hDE}, NO_RESULT},
		'{1'b0, '{1'b0, 8'hAD}, NO_RESULT},
		'{1'b0, '{1'b0, 8'hBE}, NO_RESULT},
		'{1'b1, '{1'b0, 8'hEF}, WANT_KEY},
		'{1'b0, '{1'b0, 8'h00}, NO_RESULT},
		'{1'b0, '{1'b0, 8'h01}, NO_RESULT},
		'{1'b0, '{1'b0, 8'h00}, NO_RESULT},
		'{1'b1, '{1'b0, 8'h01}, WANT_ERR_LEN},
		'{1'b0, '{1'b1, 8'hA5}, NO_RESULT},
		'{1'b0, '{1'b0, 8'h80}, NO_RESULT},
		'{1'b0, '{1'b0, 8'h00}, NO_RESULT},
		'{1'b0, '{1'b0, 8'h00}, NO_RESULT},
		'{1'b1, '{1'b0, 8'h07}, WANT_ERR_CTL},
		'{1'b0, '{1'b1, 8'h5A}, NO_RESULT},
		'{1'b0, '{1'b0, 8'h00}, NO_RESULT},
		'{1'b0, '{1'b0, 8'h00}, NO_RESULT},
		'{1'b0, '{1'b0, 8'h00}, NO_RESULT},
		'{1'b0, '{1'b0, 8'h01}, NO_RESULT},
		'{1'b1, '{1'b0, 8'h00}, WANT_ERR_NUL}
	};

	logic      clk = 1'b0;
	logic      arst_n;
	logic      item_valid;
	logic      item_stall;
	in_item_t  item;
	logic      result_valid;
	logic      result_stall;
	out_item_t result;

	// side information for the item on the bus
	logic      drv_typed;
	out_item_t drv_want;

	// parser state mirror
	phase_t      prs_phase;
	logic [1:0]  prs_hdr_count;
	logic [31:0] prs_hdr_word;
	logic [16:0] prs_text_left;
	logic [2:0]  prs_ctl_index;
	logic        prs_key_down;
	logic [31:0] prs_sym_word;

	out_item_t pending_results [$];

	int unsigned mismatches = 0;
	int unsigned bytes_sent = 0;
	int unsigned live_items = 0;
	int unsigned text_seen = 0;
	int unsigned keys_seen = 0;
	int unsigned errors_seen = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 30;
	int unsigned recv_idle_pct = 30;
	int unsigned stall_left = 0;

	length_prefixed_frame_parser_top #(
		.MAX_FRAME_BYTES(MAX_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < PRINT_CAP) begin
			$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		end
		mismatches++;
	endtask

	// parser state back to its reset values
	function automatic void clear_parser();
		prs_phase = PH_HEADER;
		prs_hdr_count = '0;
		prs_hdr_word = '0;
		prs_text_left = '0;
		prs_ctl_index = '0;
		prs_key_down = 1'b0;
		prs_sym_word = '0;
	endfunction

	// advance the parser by one item, returns 1 when a result item is due
	function automatic bit parse_byte(input in_item_t it, output out_item_t res);
		logic [7:0]  b;
		logic [31:0] len;
		b = it.data_byte;
		res = '0;
		if (it.mode) begin
			clear_parser();
			return 1'b0;
		end
		case (prs_phase)
			PH_HEADER: begin
				prs_hdr_word = {prs_hdr_word[23:0], b};
				prs_hdr_count = prs_hdr_count + 2'd1;
				if (prs_hdr_count != 2'd0)
					return 1'b0;
				len = {1'b0, prs_hdr_word[30:0]};
				res.kind = KIND_ERROR;
				if (len == 0 || len > MAX_LEN) begin
					prs_phase = PH_HALTED;
					res.error_code = ERR_LENGTH;
					return 1'b1;
				end
				if (prs_hdr_word[31]) begin
					if (len != CTRL_FRAME_LEN) begin
						prs_phase = PH_HALTED;
						res.error_code = ERR_CONTROL;
						return 1'b1;
					end
					prs_ctl_index = '0;
					prs_sym_word = '0;
					prs_key_down = 1'b0;
					prs_phase = PH_CONTROL;
				end else begin
					prs_text_left = len[16:0];
					prs_phase = PH_TEXT;
				end
				res = '0;
				return 1'b0;
			end
			PH_TEXT: begin
				if (b == 8'd0) begin
					prs_phase = PH_HALTED;
					res.kind = KIND_ERROR;
					res.error_code = ERR_NUL;
					return 1'b1;
				end
				res.kind = KIND_TEXT;
				res.text_byte = b;
				res.frame_last = (prs_text_left <= 1);
				if (res.frame_last) begin
					prs_text_left = '0;
					prs_phase = PH_HEADER;
				end else begin
					prs_text_left = prs_text_left - 17'd1;
				end
				return 1'b1;
			end
			PH_CONTROL: begin
				// type byte, state byte, then the keysym msb first
				if ((prs_ctl_index == 3'd0 && b != CTRL_TYPE_KEYSYM)
						|| (prs_ctl_index == 3'd1 && b > 8'd1)) begin
					prs_phase = PH_HALTED;
					res.kind = KIND_ERROR;
					res.error_code = ERR_CONTROL;
					return 1'b1;
				end
				if (prs_ctl_index == 3'd1)
					prs_key_down = b[0];
				else if (prs_ctl_index != 3'd0)
					prs_sym_word = {prs_sym_word[23:0], b};
				prs_ctl_index = prs_ctl_index + 3'd1;
				if (prs_ctl_index >= CTRL_FRAME_LEN) begin
					res.kind = KIND_KEY;
					res.key_symbol = prs_sym_word;
					res.key_pressed = prs_key_down;
					prs_ctl_index = '0;
					prs_phase = PH_HEADER;
					return 1'b1;
				end
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	// compare one accepted result item with the oldest expectation
	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("unexpected result kind", 32'(got.kind), '0);
			return;
		end
		want = pending_results.pop_front();
		case (want.kind)
			KIND_TEXT: text_seen++;
			KIND_KEY: keys_seen++;
			default: errors_seen++;
		endcase
		if (got.kind !== want.kind)
			report_mismatch("kind", 32'(got.kind), 32'(want.kind));
		if (got.text_byte !== want.text_byte)
			report_mismatch("text_byte", 32'(got.text_byte), 32'(want.text_byte));
		if (got.frame_last !== want.frame_last)
			report_mismatch("frame_last", 32'(got.frame_last), 32'(want.frame_last));
		if (got.key_symbol !== want.key_symbol)
			report_mismatch("key_symbol", got.key_symbol, want.key_symbol);
		if (got.key_pressed !== want.key_pressed)
			report_mismatch("key_pressed", 32'(got.key_pressed), 32'(want.key_pressed));
		if (got.error_code !== want.error_code)
			report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
	endtask

	// sample both handshakes at the rising edge
	always @(posedge clk) begin
		out_item_t predicted;
		bit        due;
		if (arst_n) begin
			if (result_valid && !result_stall)
				check_result(result);
			if (item_valid && !item_stall) begin
				due = parse_byte(item, predicted);
				if (drv_typed)
					pending_results.push_back(drv_want);
				else if (due)
					pending_results.push_back(predicted);
			end
		end
	end

	// result side stalls in bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
			result_stall <= 1'b1;
			stall_left = $urandom_range(1, 16) - 1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// present one item, starting and ending at a falling edge
	task automatic drive(input logic mode_bit, input logic [7:0] b, input bit typed,
			input out_item_t want);
		int unsigned gap;
		if (mode_bit || prs_phase != PH_HALTED)
			live_items++;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 16);
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= '{mode_bit, b};
		drv_typed <= typed;
		drv_want <= want;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		drive(1'b0, b, 1'b0, NO_RESULT);
	endtask

	task automatic send_conn();
		drive(1'b1, 8'($urandom_range(255)), 1'b0, NO_RESULT);
	endtask

	// frame header, msb first
	task automatic send_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			send_byte(w[i*8 +: 8]);
	endtask

	initial begin
		int unsigned pick;
		int unsigned len;
		int unsigned cut;
		logic [31:0] hdr;
		logic [7:0]  key_bytes [6];
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		drv_typed = 1'b0;
		drv_want = '0;
		result_stall = 1'b0;
		clear_parser();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows
		foreach (DIRECTED[i])
			drive(DIRECTED[i].it.mode, DIRECTED[i].it.data_byte, DIRECTED[i].typed,
				DIRECTED[i].want);

		// text frame opened at the largest length, cut by a new connection, no idling
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_conn();
		send_word(MAX_LEN);
		repeat (MAX_FRAME_PART) send_byte(8'($urandom_range(1, 255)));
		send_conn();

		// random frames, mostly well formed
		live_items = 0;
		while (live_items < RANDOM_ITEMS) begin
			if (live_items + QUIET_TAIL >= RANDOM_ITEMS) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if ($urandom_range(15) == 0) begin
				pick = $urandom_range(3);
				send_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : (pick == 2) ? 30 : 60;
				pick = $urandom_range(3);
				recv_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : (pick == 2) ? 30 : 60;
			end
			// halted parser: a few ignored bytes, then a fresh connection
			if (prs_phase == PH_HALTED) begin
				repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(255)));
				send_conn();
			end
			pick = $urandom_range(99);
			if (pick < 36) begin
				// text frame, mostly short, rare nul
				len = ($urandom_range(4) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
				send_word(len);
				for (int i = 0; i < len; i++) begin
					send_byte(($urandom_range(49) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
					if (prs_phase == PH_HALTED)
						break;
				end
			end else if (pick < 72) begin
				// key event frame, sometimes with a bad type or state byte
				key_bytes[0] = ($urandom_range(19) == 0) ? 8'($urandom_range(255))
					: CTRL_TYPE_KEYSYM;
				key_bytes[1] = ($urandom_range(19) == 0) ? 8'($urandom_range(2, 255))
					: 8'($urandom_range(1));
				for (int i = 2; i < 6; i++)
					key_bytes[i] = 8'($urandom_range(255));
				send_word(32'h8000_0000 | CTRL_FRAME_LEN);
				for (int i = 0; i < 6; i++) begin
					send_byte(key_bytes[i]);
					if (prs_phase == PH_HALTED)
						break;
				end
			end else if (pick < 80) begin
				// bad header
				case ($urandom_range(3))
					0: hdr = '0;
					1: hdr = $urandom_range(MAX_LEN + 1, 32'h7FFF_FFFF);
					2: hdr = 32'h8000_0000 | (($urandom_range(1) == 0) ? $urandom_range(1, 5)
						: $urandom_range(CTRL_FRAME_LEN + 1, MAX_LEN));
					default: hdr = ($urandom_range(1) == 0) ? 32'hFFFF_FFFF : 32'h8000_0000;
				endcase
				send_word(hdr);
			end else if (pick < 87) begin
				send_conn();
			end else if (pick < 94) begin
				// text frame cut short by a new connection
				len = $urandom_range(2, 8);
				cut = $urandom_range(0, len - 1);
				send_word(len);
				repeat (cut) send_byte(8'($urandom_range(1, 255)));
				send_conn();
			end else begin
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
			end
		end
		item_valid <= 1'b0;

		// drain
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", pending_results.size(), 0);

		$display("tb: %0d bytes sent, one frame opened at the largest length of %0d",
			bytes_sent, MAX_LEN);
		$display("tb: checked %0d text, %0d key event and %0d error items",
			text_seen, keys_seen, errors_seen);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: sim.f
design/lpfp_pkg.sv
design/lpfp_front.sv
design/lpfp_queue.sv
design/lpfp_back.sv
design/length_prefixed_frame_parser_top.sv
tb/length_prefixed_frame_parser_top_tb.sv
